@@ src/plss_pkg.sv @@
// ----------------------------------------------------------------------------
// plss_pkg
// Shared types and codes for the positional list shift store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package plss_pkg;

    localparam int DATA_W   = 32;
    localparam int POS_W    = 6;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 6;

    typedef enum logic [OP_W-1:0] {
        OP_GET    = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2
    } plss_op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } plss_status_t;

    // shift command broadcast along the cell row
    typedef struct packed {
        logic shift_up;    // insert: cells above the position take the lower neighbor
        logic shift_down;  // delete: cells at/above the position take the upper neighbor
    } plss_shift_t;

endpackage

@@ src/plss_cell.sv @@
// ----------------------------------------------------------------------------
// plss_cell
// One list slot: holds an element, shifts with its neighbors, and drives
// its element onto the read bus when the position selects it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module plss_cell #(
    parameter int INDEX = 0
) (
    input  logic                                 clk,
    input  plss_pkg::plss_shift_t                ctl,
    input  logic [plss_pkg::POS_W-1:0]           pos0,       // 0-based position
    input  logic [plss_pkg::DATA_W-1:0]          ins_value,
    input  logic [plss_pkg::DATA_W-1:0]          lower_data, // cell INDEX-1
    input  logic [plss_pkg::DATA_W-1:0]          upper_data, // cell INDEX+1
    output logic [plss_pkg::DATA_W-1:0]          data,
    output logic [plss_pkg::DATA_W-1:0]          rd_data
);

    logic [plss_pkg::DATA_W-1:0] slot_reg;
    logic [plss_pkg::DATA_W-1:0] slot_next;
    logic                        hit;
    logic                        above;

    assign hit   = (INDEX == int'(pos0));
    assign above = (INDEX > int'(pos0));

    always_comb
    begin
        slot_next = slot_reg;
        if (ctl.shift_up)
        begin
            if (hit)
                slot_next = ins_value;
            else if (above)
                slot_next = lower_data;
        end
        else if (ctl.shift_down)
        begin
            if (hit || above)
                slot_next = upper_data;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

    assign data    = slot_reg;
    assign rd_data = hit ? slot_reg : '0;

endmodule

@@ src/positional_list_shift_store.sv @@
// ----------------------------------------------------------------------------
// positional_list_shift_store
// Fixed-capacity ordered list with get, insert-before and delete by
// 1-based position, built as a row of shifting slot cells.
// ----------------------------------------------------------------------------
// An accepted item's result is captured in the output register and is valid in the next cycle.
// Throughput: 1 item per cycle; all cells shift together in the accept cycle.
// The input stalls only while the output register holds an untaken result.
// Reset clears the fill count and output valid; slot contents are not reset
// and are only read at positions 1..count, which always hold written items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module positional_list_shift_store #(
    parameter int CAPACITY = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // opcode[1:0], position[7:2], value[39:8]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata   // status[1:0], element[33:2], count[39:34]
);

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > plss_pkg::POS_W) ? CW : plss_pkg::POS_W;

    logic [plss_pkg::OP_W-1:0]     opcode;
    logic [plss_pkg::POS_W-1:0]    position;
    logic [plss_pkg::DATA_W-1:0]   value;
    logic [plss_pkg::POS_W-1:0]    pos0;

    logic [CW-1:0]                 fill_reg;
    logic [CW-1:0]                 fill_next;
    logic [CW-1:0]                 fill_calc;
    logic [CMPW-1:0]               fill_ext;
    logic [CMPW-1:0]               pos_ext;

    logic                          in_accept;
    logic                          out_valid_reg;
    logic [39:0]                   out_data_reg;

    plss_pkg::plss_status_t        status;
    logic [plss_pkg::DATA_W-1:0]   element;
    logic                          do_ins;
    logic                          do_del;
    plss_pkg::plss_shift_t         ctl;

    logic [plss_pkg::DATA_W-1:0]   cell_data [CAPACITY];
    logic [plss_pkg::DATA_W-1:0]   cell_rd   [CAPACITY];
    logic [plss_pkg::DATA_W-1:0]   rd_or;

    assign opcode   = s_axis_tdata[1:0];
    assign position = s_axis_tdata[7:2];
    assign value    = s_axis_tdata[39:8];
    assign pos0     = position - plss_pkg::POS_W'(1);

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign fill_ext = CMPW'(fill_reg);
    assign pos_ext  = CMPW'(position);

    // one-hot read: only the selected cell drives nonzero
    always_comb
    begin
        rd_or = '0;
        for (int k = 0; k < CAPACITY; k++)
            rd_or = rd_or | cell_rd[k];
    end

    always_comb
    begin
        status    = plss_pkg::ST_OK;
        element   = '0;
        do_ins    = 1'b0;
        do_del    = 1'b0;
        fill_calc = fill_reg;
        case (opcode)
            plss_pkg::OP_GET:
            begin
                if (fill_reg == '0)
                    status = plss_pkg::ST_EMPTY;
                else if (position == '0 || pos_ext > fill_ext)
                    status = plss_pkg::ST_RANGE;
                else
                    element = rd_or;
            end
            plss_pkg::OP_INSERT:
            begin
                if (fill_reg == CW'(CAPACITY))
                    status = plss_pkg::ST_FULL;
                else if (position == '0 || pos_ext > fill_ext + CMPW'(1))
                    status = plss_pkg::ST_RANGE;
                else
                begin
                    do_ins    = 1'b1;
                    fill_calc = fill_reg + CW'(1);
                end
            end
            plss_pkg::OP_DELETE:
            begin
                if (fill_reg == '0)
                    status = plss_pkg::ST_EMPTY;
                else if (position == '0 || pos_ext > fill_ext)
                    status = plss_pkg::ST_RANGE;
                else
                begin
                    do_del    = 1'b1;
                    element   = rd_or;
                    fill_calc = fill_reg - CW'(1);
                end
            end
            default:
            begin
                status = plss_pkg::ST_RANGE;
            end
        endcase
    end

    assign ctl.shift_up   = in_accept && do_ins;
    assign ctl.shift_down = in_accept && do_del;
    assign fill_next      = in_accept ? fill_calc : fill_reg;

    generate
        for (genvar k = 0; k < CAPACITY; k++)
        begin : g_cell
            logic [plss_pkg::DATA_W-1:0] lower;
            logic [plss_pkg::DATA_W-1:0] upper;
            if (k == 0)
            begin : g_first
                assign lower = value;
            end
            else
            begin : g_lower
                assign lower = cell_data[k-1];
            end
            if (k == CAPACITY - 1)
            begin : g_last
                assign upper = cell_data[k];
            end
            else
            begin : g_upper
                assign upper = cell_data[k+1];
            end
            plss_cell #(
                .INDEX (k)
            ) u_cell (
                .clk        (clk),
                .ctl        (ctl),
                .pos0       (pos0),
                .ins_value  (value),
                .lower_data (lower),
                .upper_data (upper),
                .data       (cell_data[k]),
                .rd_data    (cell_rd[k])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (in_accept)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            out_data_reg <= {plss_pkg::COUNT_W'(fill_calc), element, status};
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // checks
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(CAPACITY))
        else $error("fill count above capacity");

    a_ins_grows: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.shift_up |=> fill_reg == $past(fill_reg) + CW'(1))
        else $error("insert did not grow the list");

    a_err_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && status != plss_pkg::ST_OK) |=> fill_reg == $past(fill_reg))
        else $error("failed item changed the list length");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[1:0] != plss_pkg::ST_OK) |-> m_axis_tdata[33:2] == '0)
        else $error("error result carries a nonzero element");

endmodule
